// File: rtl/dpha_pkg.sv
// ============================================================================
// dpha_pkg: shared types and constants of the dual pool handle allocator
// Opcode, pool and status codes, field widths and the structs that pass
// between the top level and the two pool engines.
// ============================================================================
`default_nettype none

package dpha_pkg;

    localparam int HANDLE_W = 10;
    localparam int STATUS_W = 2;
    localparam int USED_W   = 11;

    localparam int BUFFER_SLOTS_DEF = 1024;
    localparam int IMAGE_SLOTS_DEF  = 1024;

    typedef enum logic
    {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic
    {
        POOL_BUFFER = 1'b0,
        POOL_IMAGE  = 1'b1
    } pool_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_RANGE     = 2'd2,
        ST_INACTIVE  = 2'd3
    } status_t;

    // request executing in a pool this cycle
    typedef struct packed
    {
        logic                valid;
        op_t                 opcode;
        logic [HANDLE_W-1:0] handle;
    } pool_exec_t;

    // request entering the execute register this cycle: launch memory reads
    typedef struct packed
    {
        logic                valid;
        logic [HANDLE_W-1:0] handle;
    } pool_issue_t;

    typedef struct packed
    {
        logic [HANDLE_W-1:0] granted;
        status_t             status;
        logic [USED_W-1:0]   used;
    } pool_result_t;

endpackage

`default_nettype wire

// File: rtl/dpha_ram.sv
// ============================================================================
// dpha_ram: generic simple dual port RAM
// One write port, one read port with registered read data and read enable.
// ============================================================================
`default_nettype none

module dpha_ram #(
    parameter int   WIDTH = 1,
    parameter int   DEPTH = 2,
    localparam int  AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/dpha_pool.sv
// ============================================================================
// dpha_pool: one handle pool engine
// Free stack and active bits in RAM, stack depth and low-water mark in
// registers. Executes one request per cycle and launches the reads of the
// next request in the same cycle, forwarding its own writes.
// ============================================================================
`default_nettype none

module dpha_pool #(
    parameter int SLOTS = 1024
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire dpha_pkg::pool_exec_t   exec_req,
    input  wire dpha_pkg::pool_issue_t  issue_req,
    output dpha_pkg::pool_result_t      result
);

    import dpha_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DW = $clog2(SLOTS + 1);
    localparam int CW = 17;

    localparam logic [DW-1:0] SLOTS_D  = DW'(SLOTS);
    localparam logic [DW-1:0] ONE_D    = DW'(1);
    localparam logic [AW-1:0] LAST_H   = AW'(SLOTS - 1);
    localparam logic [CW-1:0] SLOTS_C  = CW'(SLOTS);

    // Entries of the stack below lw_reg were never written, so their value is
    // taken as SLOTS - 1 - index instead of read; handles at or above SLOTS - lw_reg
    // were never given out, so their active bit is taken as clear.
    logic [DW-1:0] depth_reg, depth_next;
    logic [DW-1:0] lw_reg, lw_next;

    logic [AW-1:0] top_idx_reg;
    logic          top_fwd_reg;
    logic [AW-1:0] top_fwd_val_reg;
    logic          act_fwd_reg;
    logic          act_fwd_val_reg;

    logic          stack_we;
    logic [AW-1:0] stack_waddr;
    logic [AW-1:0] stack_wdata;
    logic [AW-1:0] stack_raddr;
    logic [AW-1:0] stack_rdata;

    logic          act_we;
    logic [AW-1:0] act_waddr;
    logic          act_wdata;
    logic [AW-1:0] act_raddr;
    logic          act_rdata;

    logic [DW-1:0] hwm;
    logic          top_fresh;
    logic [AW-1:0] top_val;
    logic [AW-1:0] handle_a;
    logic          in_range;
    logic          touched;
    logic          act_val;

    dpha_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_stack_ram (
        .clk   (clk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (stack_wdata),
        .re    (issue_req.valid),
        .raddr (stack_raddr),
        .rdata (stack_rdata)
    );

    dpha_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_active_ram (
        .clk   (clk),
        .we    (act_we),
        .waddr (act_waddr),
        .wdata (act_wdata),
        .re    (issue_req.valid),
        .raddr (act_raddr),
        .rdata (act_rdata)
    );

    // Resolve the top of stack and the active bit of the executing request.
    always_comb
    begin
        hwm       = SLOTS_D - lw_reg;
        top_fresh = (DW'(top_idx_reg) < lw_reg);
        handle_a  = AW'(exec_req.handle);
        in_range  = (CW'(exec_req.handle) < SLOTS_C);
        touched   = (CW'(exec_req.handle) < CW'(hwm));

        if (top_fwd_reg)
        begin
            top_val = top_fwd_val_reg;
        end
        else if (top_fresh)
        begin
            top_val = LAST_H - top_idx_reg;
        end
        else
        begin
            top_val = stack_rdata;
        end

        if (act_fwd_reg)
        begin
            act_val = act_fwd_val_reg;
        end
        else
        begin
            act_val = touched & act_rdata;
        end
    end

    // Execute: pop or push, update active bit and counters.
    always_comb
    begin
        depth_next     = depth_reg;
        lw_next        = lw_reg;
        stack_we       = 1'b0;
        stack_waddr    = AW'(depth_reg);
        stack_wdata    = handle_a;
        act_we         = 1'b0;
        act_waddr      = handle_a;
        act_wdata      = 1'b0;
        result.granted = '0;
        result.status  = ST_OK;

        if (exec_req.valid)
        begin
            case (exec_req.opcode)
                OP_ALLOC:
                begin
                    if (depth_reg == '0)
                    begin
                        result.status = ST_EXHAUSTED;
                    end
                    else
                    begin
                        depth_next     = depth_reg - ONE_D;
                        act_we         = 1'b1;
                        act_waddr      = top_val;
                        act_wdata      = 1'b1;
                        result.granted = HANDLE_W'(top_val);
                        if (depth_reg == lw_reg)
                        begin
                            lw_next = lw_reg - ONE_D;
                        end
                    end
                end
                OP_FREE:
                begin
                    if (!in_range)
                    begin
                        result.status = ST_RANGE;
                    end
                    else if (!act_val || depth_reg == SLOTS_D)
                    begin
                        result.status = ST_INACTIVE;
                    end
                    else
                    begin
                        depth_next = depth_reg + ONE_D;
                        stack_we   = 1'b1;
                        act_we     = 1'b1;
                        act_wdata  = 1'b0;
                    end
                end
                default:
                begin
                    result.status = ST_OK;
                end
            endcase
        end

        result.used = USED_W'(SLOTS_D - depth_next);
    end

    // The stack read address of the next request follows the post-execute depth.
    assign stack_raddr = AW'(depth_next - ONE_D);
    assign act_raddr   = AW'(issue_req.handle);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg   <= SLOTS_D;
            lw_reg      <= SLOTS_D;
            top_fwd_reg <= 1'b0;
            act_fwd_reg <= 1'b0;
        end
        else
        begin
            depth_reg <= depth_next;
            lw_reg    <= lw_next;
            if (issue_req.valid)
            begin
                // a push this cycle lands exactly on the next read index
                top_fwd_reg <= stack_we;
                act_fwd_reg <= act_we && (act_waddr == AW'(issue_req.handle));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue_req.valid)
        begin
            top_idx_reg     <= stack_raddr;
            top_fwd_val_reg <= stack_wdata;
            act_fwd_val_reg <= act_wdata;
        end
    end

endmodule

`default_nettype wire

// File: rtl/dual_pool_handle_allocator_core.sv
// ============================================================================
// dual_pool_handle_allocator_core: two-pool free list handle allocator
// Buffer and image pools, each a LIFO stack of free handles with one active
// bit per handle; allocate pops, free pushes back a valid active handle.
// ============================================================================
//
// Channel  Dir  tdata / tuser contents (lowest bit first)
// -------  ---  ------------------------------------------------------------
// s_axis   in   tuser: opcode[0], pool_select[1]; tdata: free_handle[9:0]
// m_axis   out  tdata: granted_handle[9:0], status[11:10], used_count[22:12]
//
// One transaction is accepted per cycle while s_axis_tready is high. It
// enters the execute register, is executed against that pool's stack and
// active RAMs once the output register can take its result, and its result
// lands in the output register at the end of that execute cycle. The
// execute stage is sized by the read-modify-write of the stack RAM and
// depth counter.
// Reset is immediate: no clearing pass; a low-water mark per pool tracks the
// stack entries and handles never touched since reset.
// A stalled output holds the output register, then the execute register,
// then drops s_axis_tready.
// ============================================================================
`default_nettype none

module dual_pool_handle_allocator_core #(
    parameter int BUFFER_SLOTS = dpha_pkg::BUFFER_SLOTS_DEF,
    parameter int IMAGE_SLOTS  = dpha_pkg::IMAGE_SLOTS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // free_handle[9:0], zero pad
    input  wire logic [1:0]  s_axis_tuser,   // opcode[0], pool_select[1]

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata    // granted_handle[9:0], status[11:10],
                                             // used_count[22:12], zero pad
);

    import dpha_pkg::*;

    localparam logic [USED_W-1:0] BUF_FULL = USED_W'(BUFFER_SLOTS);
    localparam logic [USED_W-1:0] IMG_FULL = USED_W'(IMAGE_SLOTS);

    // input transaction
    logic                in_fire;
    op_t                 in_op;
    pool_t               in_pool;
    logic [HANDLE_W-1:0] in_handle;

    // execute register
    logic                exec_valid_reg, exec_valid_next;
    op_t                 exec_op_reg;
    pool_t               exec_pool_reg;
    logic [HANDLE_W-1:0] exec_handle_reg;
    logic                exec_fire;

    // output register
    logic                out_valid_reg, out_valid_next;
    pool_result_t        out_res_reg;

    pool_exec_t          buf_exec, img_exec;
    pool_issue_t         buf_issue, img_issue;
    pool_result_t        buf_res, img_res;
    pool_result_t        exec_res;

    assign in_op     = op_t'(s_axis_tuser[0]);
    assign in_pool   = pool_t'(s_axis_tuser[1]);
    assign in_handle = s_axis_tdata[HANDLE_W-1:0];

    // advance the execute register when the output register frees up
    assign exec_fire     = exec_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !exec_valid_reg || exec_fire;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        buf_exec.valid   = exec_fire && (exec_pool_reg == POOL_BUFFER);
        buf_exec.opcode  = exec_op_reg;
        buf_exec.handle  = exec_handle_reg;
        img_exec.valid   = exec_fire && (exec_pool_reg == POOL_IMAGE);
        img_exec.opcode  = exec_op_reg;
        img_exec.handle  = exec_handle_reg;

        // launch the RAM reads of the incoming transaction in its own pool
        buf_issue.valid  = in_fire && (in_pool == POOL_BUFFER);
        buf_issue.handle = in_handle;
        img_issue.valid  = in_fire && (in_pool == POOL_IMAGE);
        img_issue.handle = in_handle;
    end

    dpha_pool #(.SLOTS(BUFFER_SLOTS)) u_buf_pool (
        .clk       (clk),
        .rst_n     (rst_n),
        .exec_req  (buf_exec),
        .issue_req (buf_issue),
        .result    (buf_res)
    );

    dpha_pool #(.SLOTS(IMAGE_SLOTS)) u_img_pool (
        .clk       (clk),
        .rst_n     (rst_n),
        .exec_req  (img_exec),
        .issue_req (img_issue),
        .result    (img_res)
    );

    assign exec_res = (exec_pool_reg == POOL_IMAGE) ? img_res : buf_res;

    always_comb
    begin
        exec_valid_next = exec_valid_reg;
        if (in_fire)
        begin
            exec_valid_next = 1'b1;
        end
        else if (exec_fire)
        begin
            exec_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (exec_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exec_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            exec_valid_reg <= exec_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // hold payload until the next transaction moves in
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            exec_op_reg     <= in_op;
            exec_pool_reg   <= in_pool;
            exec_handle_reg <= in_handle;
        end
        if (exec_fire)
        begin
            out_res_reg <= exec_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_res_reg.used, out_res_reg.status,
                            out_res_reg.granted};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // an exhausted pool has every handle in use
    a_exhausted_full: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire && exec_res.status == ST_EXHAUSTED |->
            ((exec_pool_reg == POOL_BUFFER && exec_res.used == BUF_FULL) ||
             (exec_pool_reg == POOL_IMAGE && exec_res.used == IMG_FULL)))
        else $error("exhausted reported with free handles left");

    // a free that succeeds always leaves the pool short of full use
    a_free_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire && exec_op_reg == OP_FREE && exec_res.status == ST_OK |->
            ((exec_pool_reg == POOL_BUFFER && exec_res.used != BUF_FULL) ||
             (exec_pool_reg == POOL_IMAGE && exec_res.used != IMG_FULL)))
        else $error("successful free left the pool fully used");

    // a nonzero handle is granted only by a successful allocate
    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire && exec_res.granted != '0 |->
            exec_res.status == ST_OK && exec_op_reg == OP_ALLOC)
        else $error("handle granted outside a successful allocate");

    // a transaction executing this cycle shows up on the output next cycle
    a_exec_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire |=> m_axis_tvalid)
        else $error("executed transaction lost before output");

endmodule

`default_nettype wire

// File: tb/tb_dual_pool_handle_allocator_core.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_dual_pool_handle_allocator_core: self-checking bench for the allocator
// Drives allocate and free transactions into both handle pools, predicts
// every result with a private model of the two free stacks and active maps,
// and compares each output transaction field by field in arrival order.
// ============================================================================

module tb_dual_pool_handle_allocator_core;

    import dpha_pkg::*;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n;

    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;     // free_handle[9:0], zero pad
    logic [1:0]  s_axis_tuser;     // opcode[0], pool_select[1]

    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;     // granted_handle[9:0], status[11:10],
                                   // used_count[22:12], zero pad

    // 4 ns period: two phases of 2 ns each
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    dual_pool_handle_allocator_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // ------------------------------------------------------------------------
    // Shadow copy of both pools, indexed by pool_select
    // ------------------------------------------------------------------------
    int                  pool_slots   [2] = '{BUFFER_SLOTS_DEF, IMAGE_SLOTS_DEF};
    logic [HANDLE_W-1:0] free_stack   [2][1024];
    int                  free_depth   [2];
    bit                  active_map   [2][1024];

    // Results owed by the block, oldest first
    pool_result_t        pending_results [$];

    int                  mismatch_count   = 0;
    bit                  gaps_enabled     = 1'b0;  // random idling on both sides
    int                  long_hold_cycles = 0;     // request a long output stall

    // ------------------------------------------------------------------------
    // Apply one request to the shadow pools and return the result it owes.
    // Allocate pops the top of the free stack; free pushes back only a handle
    // that is in range and active. Failed requests leave the pool untouched.
    // ------------------------------------------------------------------------
    function automatic pool_result_t apply_pool_request(input op_t op,
                                                        input pool_t pool,
                                                        input logic [HANDLE_W-1:0] handle);
        pool_result_t r;
        int p;
        int slots;
        int top;
        p = int'(pool);
        slots = pool_slots[p];
        r.granted = '0;
        r.status = ST_OK;
        if (op == OP_ALLOC)
        begin
            // empty stack: report exhaustion, hand out nothing
            if (free_depth[p] == 0 || free_depth[p] > slots)
                r.status = ST_EXHAUSTED;
            else
            begin
                top = int'(free_stack[p][free_depth[p] - 1]);
                if (top < slots)
                begin
                    free_depth[p]--;
                    active_map[p][top] = 1'b1;
                    r.granted = HANDLE_W'(top);
                end
                else
                    r.status = ST_EXHAUSTED;
            end
        end
        else if (int'(handle) >= slots)
            r.status = ST_RANGE;
        else if (!active_map[p][handle])
            r.status = ST_INACTIVE;     // never handed out, or freed already
        else if (free_depth[p] < slots)
        begin
            free_stack[p][free_depth[p]] = handle;
            free_depth[p]++;
            active_map[p][handle] = 1'b0;
        end
        else
            r.status = ST_INACTIVE;
        r.used = USED_W'(slots - free_depth[p]);
        return r;
    endfunction

    // Move handle to the next active one in the pool, starting at its value;
    // leave it alone when the pool has nothing active.
    function automatic void seek_active_handle(input pool_t pool,
                                               inout logic [HANDLE_W-1:0] handle);
        int k;
        int probe;
        for (k = 0; k < pool_slots[int'(pool)]; k++)
        begin
            probe = (int'(handle) + k) % pool_slots[int'(pool)];
            if (active_map[int'(pool)][probe])
            begin
                handle = HANDLE_W'(probe);
                return;
            end
        end
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 50)
            return 0;
        else if (roll < 85)
            return $urandom_range(3, 1);
        else if (roll < 96)
            return $urandom_range(12, 4);
        else
            return $urandom_range(60, 20);
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // ------------------------------------------------------------------------
    // Send one request transaction. Hold tvalid high between back-to-back
    // transactions; drop it only when an idle gap is inserted. Predict the
    // result at the accepting edge so the shadow pools track the block.
    // ------------------------------------------------------------------------
    task automatic send_request(input op_t op, input pool_t pool,
                                input logic [HANDLE_W-1:0] handle);
        int gap;
        gap = gaps_enabled ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, handle};
        s_axis_tuser  <= {pool, op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_results.insert(pending_results.size(),
                               apply_pool_request(op, pool, handle));
    endtask

    // ------------------------------------------------------------------------
    // Output side: stall at random, or hold off for a long counted stretch
    // when a test asks for it, so the pipeline fills and s_axis_tready drops.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (long_hold_cycles) @(posedge clk);
                long_hold_cycles = 0;
                m_axis_tready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (gaps_enabled && $urandom_range(5) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Compare every output transaction with the oldest owed result
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_checker
        pool_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("output transaction with no request outstanding");
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata[9:0] !== want.granted)
                    report_mismatch($sformatf("granted_handle got %0d want %0d",
                                              m_axis_tdata[9:0], want.granted));
                if (m_axis_tdata[11:10] !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              m_axis_tdata[11:10], want.status));
                if (m_axis_tdata[22:12] !== want.used)
                    report_mismatch($sformatf("used_count got %0d want %0d",
                                              m_axis_tdata[22:12], want.used));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Hand-picked sequence from reset: ascending first grants, LIFO reuse,
    // double free, free of a never-granted handle, allocate ignoring the
    // handle field, free on an empty pool. With both pools at 1024 slots no
    // 10-bit handle is out of range, so that status cannot occur here.
    task automatic test_directed();
        send_request(OP_ALLOC, POOL_BUFFER, 10'h000);   // grants 0
        send_request(OP_ALLOC, POOL_BUFFER, 10'h3FF);   // handle field ignored
        send_request(OP_ALLOC, POOL_IMAGE,  10'h000);
        send_request(OP_FREE,  POOL_BUFFER, 10'd1);
        send_request(OP_FREE,  POOL_BUFFER, 10'd1);     // double free
        send_request(OP_ALLOC, POOL_BUFFER, 10'h155);   // reuses last freed
        send_request(OP_FREE,  POOL_BUFFER, 10'h3FF);   // never granted
        send_request(OP_FREE,  POOL_IMAGE,  10'd0);     // image pool back to empty
        send_request(OP_FREE,  POOL_IMAGE,  10'd0);     // free with nothing in use
        send_request(OP_ALLOC, POOL_IMAGE,  10'h2AA);
        send_request(OP_FREE,  POOL_BUFFER, 10'd0);
        send_request(OP_FREE,  POOL_BUFFER, 10'd2);     // not yet granted
        send_request(OP_ALLOC, POOL_BUFFER, 10'h000);
        send_request(OP_ALLOC, POOL_BUFFER, 10'h000);
        send_request(OP_FREE,  POOL_BUFFER, 10'h2AA);
        send_request(OP_FREE,  POOL_IMAGE,  10'h155);
        send_request(OP_FREE,  POOL_IMAGE,  10'h3FF);
    endtask

    // Mixed traffic on both pools: mostly allocates and frees of live
    // handles, with some frees of random handles as noise. Alternate
    // stretches with and without idling.
    task automatic test_random_traffic(input int count);
        int i;
        int roll;
        pool_t pool;
        logic [HANDLE_W-1:0] handle;
        for (i = 0; i < count; i++)
        begin
            gaps_enabled = (i % 50) < 35;
            pool = pool_t'($urandom_range(1));
            handle = HANDLE_W'($urandom);
            roll = $urandom_range(99);
            if (roll < 55)
                send_request(OP_ALLOC, pool, handle);
            else
            begin
                if (roll < 90)
                    seek_active_handle(pool, handle);
                send_request(OP_FREE, pool, handle);
            end
        end
        gaps_enabled = 1'b1;
    endtask

    // Drain the buffer pool to empty, then keep allocating to hit exhaustion.
    // Open with a long output hold so the block backs up onto its input.
    task automatic test_buffer_exhaustion();
        int extra;
        long_hold_cycles = 300;
        while (free_depth[int'(POOL_BUFFER)] > 0)
            send_request(OP_ALLOC, POOL_BUFFER, HANDLE_W'($urandom));
        for (extra = 0; extra < 4; extra++)
            send_request(OP_ALLOC, POOL_BUFFER, HANDLE_W'($urandom));
        // free one from a full pool and take it straight back
        send_request(OP_FREE,  POOL_BUFFER, 10'd517);
        send_request(OP_ALLOC, POOL_BUFFER, 10'h000);
        send_request(OP_ALLOC, POOL_BUFFER, 10'h000);
    endtask

    // ------------------------------------------------------------------------
    // Sequencer: reset, run the tests in turn, drain, decide
    // ------------------------------------------------------------------------
    initial
    begin : sequencer
        int p;
        int i;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;

        // shadow pools at reset: handle 0 on top of each stack
        for (p = 0; p < 2; p++)
        begin
            for (i = 0; i < pool_slots[p]; i++)
            begin
                free_stack[p][i] = HANDLE_W'(pool_slots[p] - 1 - i);
                active_map[p][i] = 1'b0;
            end
            free_depth[p] = pool_slots[p];
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic(12);
        test_buffer_exhaustion();
        test_random_traffic(12);

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // two-stage pipeline: let any stray output show up
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // About 1070 transactions; even with every gap and stall at its longest
    // the run needs well under a third of this window.
    initial
    begin : watchdog
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
